[rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Types, constants and helpers for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

	localparam int NEWTON_STEPS = 4;
	localparam logic [30:0] SEED_LOW  = 31'd894784853;
	localparam logic [30:0] SEED_HIGH = 31'd632708529;
	localparam logic signed [17:0] ONE_Q14 = 18'sd16384;
	localparam logic [31:0] THREE_Q30 = 32'hC000_0000;
	localparam logic [5:0] SHIFT_BASE = 6'd38;

	// values that travel with an item through the iteration stages
	typedef struct packed {
		logic              degen;
		logic [3:0]        k;
		logic [29:0]       u;
		logic signed [17:0] dw;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [17:0] dz;
	} ctx_t;

	function automatic logic [16:0] abs18(input logic signed [17:0] d);
		logic signed [17:0] n;
		n = -d;
		return d[17] ? n[16:0] : d[16:0];
	endfunction

	// shift down, apply sign, saturate to q2.14
	function automatic logic signed [15:0] scale_sat(input logic [47:0] prod,
			input logic neg, input logic [5:0] sh);
		logic [47:0] p;
		logic [47:0] n;
		p = prod >> sh;
		n = -p;
		if (neg) begin
			return (p > 48'd32768) ? 16'sh8000 : n[15:0];
		end else begin
			return (p > 48'd32767) ? 16'sh7fff : p[15:0];
		end
	endfunction

endpackage

`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// one transaction per cycle while the output is not stalled
// throughput is set by the fully pipelined newton iteration: four steps of
// three multiplier stages each, plus two front and two output stages
// a stall at the output freezes every stage; the input stalls only then
// arst_n clears the valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a q2.14 rotation matrix to a q2.14 quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               mat_valid,
	output logic                    mat_stall,
	input  wire logic signed [15:0] e11,
	input  wire logic signed [15:0] e12,
	input  wire logic signed [15:0] e13,
	input  wire logic signed [15:0] e21,
	input  wire logic signed [15:0] e22,
	input  wire logic signed [15:0] e23,
	input  wire logic signed [15:0] e31,
	input  wire logic signed [15:0] e32,
	input  wire logic signed [15:0] e33,
	output logic                    quat_valid,
	input  wire logic               quat_stall,
	output logic signed [15:0]      quat_w,
	output logic signed [15:0]      quat_x,
	output logic signed [15:0]      quat_y,
	output logic signed [15:0]      quat_z,
	output logic                    degenerate
);
	import rmq_pkg::*;

	logic en;
	assign en = !quat_valid || !quat_stall;
	assign mat_stall = !en;

	// stage 1: branch select
	logic signed [17:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;
	logic signed [17:0] tr, t_c, dw_c, dx_c, dy_c, dz_c;
	assign a11 = {{2{e11[15]}}, e11};
	assign a12 = {{2{e12[15]}}, e12};
	assign a13 = {{2{e13[15]}}, e13};
	assign a21 = {{2{e21[15]}}, e21};
	assign a22 = {{2{e22[15]}}, e22};
	assign a23 = {{2{e23[15]}}, e23};
	assign a31 = {{2{e31[15]}}, e31};
	assign a32 = {{2{e32[15]}}, e32};
	assign a33 = {{2{e33[15]}}, e33};
	assign tr = a11 + a22 + a33;

	always_comb begin
		if (tr > 18'sd0) begin
			t_c = tr + ONE_Q14;
			dw_c = t_c; dx_c = a23 - a32; dy_c = a31 - a13; dz_c = a12 - a21;
		end else if (a11 > a22 && a11 > a33) begin
			t_c = ONE_Q14 + a11 - a22 - a33;
			dw_c = a23 - a32; dx_c = t_c; dy_c = a12 + a21; dz_c = a13 + a31;
		end else if (a22 > a33) begin
			t_c = ONE_Q14 + a22 - a11 - a33;
			dw_c = a31 - a13; dx_c = a12 + a21; dy_c = t_c; dz_c = a23 + a32;
		end else begin
			t_c = ONE_Q14 + a33 - a11 - a22;
			dw_c = a12 - a21; dx_c = a31 + a13; dy_c = a32 + a23; dz_c = t_c;
		end
	end

	logic               v_s1;
	logic signed [17:0] t_s1, dw_s1, dx_s1, dy_s1, dz_s1;

	// stage 2: normalize t into u = t << 2k
	logic [3:0]  k_c;
	logic [45:0] sh_c;
	logic [45:0] u_c;
	always_comb begin
		k_c = 4'd14;
		for (int j = 14; j >= 0; j--) begin
			sh_c = {29'd0, t_s1[16:0]} << (2 * j);
			if (sh_c >= 46'h1000_0000) k_c = 4'(j);
		end
		u_c = {29'd0, t_s1[16:0]} << {k_c, 1'b0};
	end

	logic v_s2;
	ctx_t ctx_s2;

	// newton iteration, three stages per step
	logic [NEWTON_STEPS-1:0] v_sa, v_sb, v_sc, v_in;
	ctx_t        ctx_sa [NEWTON_STEPS];
	ctx_t        ctx_sb [NEWTON_STEPS];
	ctx_t        ctx_sc [NEWTON_STEPS];
	ctx_t        ctx_in [NEWTON_STEPS];
	logic [30:0] y_sa   [NEWTON_STEPS];
	logic [30:0] y_sb   [NEWTON_STEPS];
	logic [30:0] y_sc   [NEWTON_STEPS];
	logic [30:0] y_in   [NEWTON_STEPS];
	logic [31:0] y2_sa  [NEWTON_STEPS];
	logic [33:0] p_sb   [NEWTON_STEPS];

	genvar i;
	generate
		for (i = 0; i < NEWTON_STEPS; i++) begin : g_newton
			logic [61:0] yy;
			logic [61:0] uy;
			logic [31:0] f;
			logic [62:0] yf;

			if (i == 0) begin : g_first
				assign v_in[i] = v_s2;
				assign ctx_in[i] = ctx_s2;
				assign y_in[i] = ctx_s2.u[29] ? SEED_HIGH : SEED_LOW;
			end else begin : g_next
				assign v_in[i] = v_sc[i-1];
				assign ctx_in[i] = ctx_sc[i-1];
				assign y_in[i] = y_sc[i-1];
			end

			assign yy = {31'd0, y_in[i]} * {31'd0, y_in[i]};
			assign uy = {32'd0, ctx_sa[i].u} * {30'd0, y2_sa[i]};
			assign f = (p_sb[i] < {2'd0, THREE_Q30}) ? (THREE_Q30 - p_sb[i][31:0]) : 32'd0;
			assign yf = {32'd0, y_sb[i]} * {31'd0, f};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sa[i] <= 1'b0;
					v_sb[i] <= 1'b0;
					v_sc[i] <= 1'b0;
				end else if (en) begin
					v_sa[i] <= v_in[i];
					v_sb[i] <= v_sa[i];
					v_sc[i] <= v_sb[i];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					ctx_sa[i] <= ctx_in[i];
					y_sa[i]   <= y_in[i];
					y2_sa[i]  <= yy[61:30];
					ctx_sb[i] <= ctx_sa[i];
					y_sb[i]   <= y_sa[i];
					p_sb[i]   <= uy[61:28];
					ctx_sc[i] <= ctx_sb[i];
					y_sc[i]   <= yf[61:31];
				end
			end
		end
	endgenerate

	// output multiply and saturate
	ctx_t        ctx_last;
	logic [30:0] y_last;
	assign ctx_last = ctx_sc[NEWTON_STEPS-1];
	assign y_last = y_sc[NEWTON_STEPS-1];

	logic        v_s3;
	logic        degen_s3;
	logic [5:0]  sh_s3;
	logic [3:0]  neg_s3;
	logic [47:0] pw_s3, px_s3, py_s3, pz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			quat_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= mat_valid;
			v_s2 <= v_s1;
			v_s3 <= v_sc[NEWTON_STEPS-1];
			quat_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= t_c;
			dw_s1 <= dw_c;
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			dz_s1 <= dz_c;

			ctx_s2.degen <= t_s1[17] || (t_s1 == 18'sd0);
			ctx_s2.k     <= k_c;
			ctx_s2.u     <= u_c[29:0];
			ctx_s2.dw    <= dw_s1;
			ctx_s2.dx    <= dx_s1;
			ctx_s2.dy    <= dy_s1;
			ctx_s2.dz    <= dz_s1;

			degen_s3 <= ctx_last.degen;
			sh_s3    <= SHIFT_BASE - {2'd0, ctx_last.k};
			neg_s3   <= {ctx_last.dz[17], ctx_last.dy[17], ctx_last.dx[17], ctx_last.dw[17]};
			pw_s3    <= {31'd0, abs18(ctx_last.dw)} * {17'd0, y_last};
			px_s3    <= {31'd0, abs18(ctx_last.dx)} * {17'd0, y_last};
			py_s3    <= {31'd0, abs18(ctx_last.dy)} * {17'd0, y_last};
			pz_s3    <= {31'd0, abs18(ctx_last.dz)} * {17'd0, y_last};

			degenerate <= degen_s3;
			if (degen_s3) begin
				quat_w <= 16'sd0;
				quat_x <= 16'sd0;
				quat_y <= 16'sd0;
				quat_z <= 16'sd0;
			end else begin
				quat_w <= scale_sat(pw_s3, neg_s3[0], sh_s3);
				quat_x <= scale_sat(px_s3, neg_s3[1], sh_s3);
				quat_y <= scale_sat(py_s3, neg_s3[2], sh_s3);
				quat_z <= scale_sat(pz_s3, neg_s3[3], sh_s3);
			end
		end
	end

endmodule

`default_nettype wire
